[design/two_contact_key_velocity_scanner_defines.svh]
// ----------------------------------------------------------------------------
// Two-contact key velocity scanner assertion macros
// Shorthand for the concurrent checks of the scanner checker.
// ----------------------------------------------------------------------------
`ifndef TWO_CONTACT_KEY_VELOCITY_SCANNER_DEFINES_SVH
`define TWO_CONTACT_KEY_VELOCITY_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCKVS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCKVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tckvs_pkg.sv]
// ----------------------------------------------------------------------------
// Two-contact key velocity scanner package
// Shared widths, reset values, codes and the velocity curve ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package tckvs_pkg;

    localparam int NUM_KEYS_DEF  = 88;
    localparam int TICK_BITS_DEF = 32;
    localparam int TABLE_SIZE    = 180;

    localparam int KEY_W      = 7;
    localparam int VEL_W      = 7;
    localparam int NOW_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [KEY_W-1:0]      NOTE_OFFSET    = 7'd21;
    localparam logic [CFG_DATA_W-1:0] REARM_RST      = 16'd200;
    localparam logic [7:0]            MIN_FLIGHT_RST = 8'd1;
    localparam logic [7:0]            MAX_FLIGHT_RST = 8'd180;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REARM      = 2'd0,
        CFG_MIN_FLIGHT = 2'd1,
        CFG_MAX_FLIGHT = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ARMED   = 2'd1,
        PH_SOUNDED = 2'd2
    } t_phase;

    typedef logic [VEL_W-1:0] t_vel_rom [256];

    // Velocity curve 128.43 - 1.43 d + 0.00405 d^2, truncated and clamped to
    // 0..127. A zero flight gives zero and a one-tick flight gives full scale.
    function automatic t_vel_rom f_vel_rom();
        t_vel_rom rom;
        int       v;
        for (int d = 0; d < 256; d++) begin
            v = (12843000 - 143000 * d + 405 * d * d) / 100000;
            if (v < 0) begin
                v = 0;
            end
            if (v > 127) begin
                v = 127;
            end
            if (d == 0) begin
                v = 0;
            end
            if (d == 1) begin
                v = 127;
            end
            rom[d] = VEL_W'(v);
        end
        return rom;
    endfunction

    localparam t_vel_rom VEL_ROM = f_vel_rom();

endpackage

`default_nettype wire

[design/tckvs_ifs.sv]
// ----------------------------------------------------------------------------
// Two-contact key velocity scanner channels
// Valid/ready channels for key samples and for sounded notes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tckvs_key_if
    import tckvs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic             first_contact;
    logic             second_contact;
    logic [NOW_W-1:0] now_tick;

    modport source (
        output valid, key_index, first_contact, second_contact, now_tick,
        input  ready
    );
    modport sink (
        input  valid, key_index, first_contact, second_contact, now_tick,
        output ready
    );
endinterface

interface tckvs_note_if
    import tckvs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] note_number;
    logic [VEL_W-1:0] velocity;

    modport source (
        output valid, note_number, velocity,
        input  ready
    );
    modport sink (
        input  valid, note_number, velocity,
        output ready
    );
endinterface

`default_nettype wire

[design/two_contact_key_velocity_scanner.sv]
// ----------------------------------------------------------------------------
// Two-contact key velocity scanner
// Tracks press, sound and rearm per key and emits a note with a velocity
// taken from the flight time between the two contacts.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                         Transfer
//  i_key     in   key_index, first_contact, second_contact, tick  valid & ready
//  o_note    out  note_number, velocity                           valid & ready
//  i_cfg_*   in   register index, write data                      i_cfg_we
//
// One request is taken per clock unless a waiting note stalls stage one. It is registered
// with its key's state row when accepted; stage one then writes the row back and, for a
// sounding request, loads the note register. A write-back to the key being read is
// bypassed, so samples of one key may follow each other every cycle.
// Reset is synchronous and clears the pipeline, the note register and the key valid bits.
// A waiting note stalls requests only when the request behind it would also sound.
//
`default_nettype none

module two_contact_key_velocity_scanner
    import tckvs_pkg::*;
#(
    parameter int NUM_KEYS  = NUM_KEYS_DEF,
    parameter int TICK_BITS = TICK_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    tckvs_key_if.sink             i_key,
    tckvs_note_if.source          o_note,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [7:0] TBL_LAST = 8'(TABLE_SIZE - 1);

    // One memory row holds everything the scanner knows about a key.
    typedef struct packed {
        t_phase                phase;
        logic [TICK_BITS-1:0]  press;
        logic [TICK_BITS-1:0]  sound;
    } t_key_row;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_rearm;
    logic [7:0]            r_min_flight;
    logic [7:0]            r_max_flight;

    // Stage one: the registered request and the key's state row.
    logic                  r_s1_vld;
    logic [KEY_W-1:0]      r_s1_key;
    logic                  r_s1_first;
    logic                  r_s1_second;
    logic [TICK_BITS-1:0]  r_s1_now;
    t_key_row              r_rd;
    logic                  r_rd_hit;

    // Per-key state memory and its valid bits.
    t_key_row              r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]   r_row_vld;

    // Note register.
    logic                  r_out_vld;
    logic [KEY_W-1:0]      r_out_note;
    logic [VEL_W-1:0]      r_out_vel;

    logic                  in_range;
    logic                  in_ready;
    logic                  accept;
    logic [KEY_AW-1:0]     in_addr;
    logic [KEY_AW-1:0]     wr_addr;
    logic                  bypass;
    t_key_row              cur;
    t_key_row              n_row;
    logic [TICK_BITS-1:0]  since_sound;
    logic [TICK_BITS-1:0]  flight;
    logic                  rearm_ok;
    logic                  flight_ok;
    logic                  s1_emit;
    logic                  s1_done;
    logic [7:0]            vel_idx;
    logic [KEY_W-1:0]      n_note;

    // Handshake and addressing. Out-of-range keys are taken and dropped.
    assign in_range = ({1'b0, i_key.key_index} < 8'(NUM_KEYS));
    assign in_addr  = i_key.key_index[KEY_AW-1:0];
    assign wr_addr  = r_s1_key[KEY_AW-1:0];
    assign in_ready = i_rst_n && (!r_s1_vld || s1_done);
    assign accept   = i_key.valid && in_ready;
    assign bypass   = s1_done && (wr_addr == in_addr);

    assign i_key.ready        = in_ready;
    assign o_note.valid       = r_out_vld;
    assign o_note.note_number = r_out_note;
    assign o_note.velocity    = r_out_vel;

    // A key never written since reset reads as idle with zero times.
    assign cur = r_rd_hit ? r_rd : '0;

    // Key state update for the request in stage one.
    always_comb begin
        since_sound = r_s1_now - cur.sound;
        flight      = r_s1_now - cur.press;
        rearm_ok    = since_sound > TICK_BITS'(r_rearm);
        flight_ok   = (flight > TICK_BITS'(r_min_flight))
                   && (flight < TICK_BITS'(r_max_flight));
        n_row       = cur;
        s1_emit     = 1'b0;
        if (r_s1_first) begin
            if (cur.phase == PH_IDLE) begin
                if (rearm_ok) begin
                    n_row.press = r_s1_now;
                    n_row.phase = PH_ARMED;
                end
            end else if (r_s1_second && cur.phase == PH_ARMED && flight_ok) begin
                n_row.sound = r_s1_now;
                n_row.phase = PH_SOUNDED;
                s1_emit     = 1'b1;
            end
        end else if (cur.phase != PH_IDLE && rearm_ok) begin
            n_row.phase = PH_IDLE;
        end
        // Flights past the end of the curve use its last entry.
        vel_idx = (flight >= TICK_BITS'(TBL_LAST)) ? TBL_LAST : flight[7:0];
        n_note  = r_s1_key + NOTE_OFFSET;
    end

    // Stage one finishes unless it would sound into a full, stalled note slot.
    assign s1_done = r_s1_vld && (!s1_emit || !r_out_vld || o_note.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rearm      <= REARM_RST;
            r_min_flight <= MIN_FLIGHT_RST;
            r_max_flight <= MAX_FLIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_REARM:      r_rearm      <= i_cfg_data;
                CFG_MIN_FLIGHT: r_min_flight <= i_cfg_data[7:0];
                CFG_MAX_FLIGHT: r_max_flight <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // Stage one control and request payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= in_range;
        end else if (s1_done) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_s1_key    <= i_key.key_index;
            r_s1_first  <= !i_key.first_contact;
            r_s1_second <= !i_key.second_contact;
            r_s1_now    <= i_key.now_tick[TICK_BITS-1:0];
        end
    end

    // State memory: write-back from stage one, registered read with bypass.
    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_mem[wr_addr] <= n_row;
        end
        if (accept && in_range) begin
            r_rd     <= bypass ? n_row : r_mem[in_addr];
            r_rd_hit <= bypass || r_row_vld[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (s1_done) begin
            r_row_vld[wr_addr] <= 1'b1;
        end
    end

    // Note register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_done && s1_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_note.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done && s1_emit) begin
            r_out_note <= n_note;
            r_out_vel  <= VEL_ROM[vel_idx];
        end
    end

endmodule

`default_nettype wire

[design/tckvs_chk.sv]
// ----------------------------------------------------------------------------
// Two-contact key velocity scanner checker
// Port-level checks on the scanner, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "two_contact_key_velocity_scanner_defines.svh"

module tckvs_chk
    import tckvs_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_in_ready,
    input  wire              i_out_valid,
    input  wire              i_out_ready,
    input  wire [KEY_W-1:0]  i_note_number,
    input  wire [VEL_W-1:0]  i_velocity
);

    localparam logic [7:0] NOTE_LO = 8'(NOTE_OFFSET);
    localparam logic [7:0] NOTE_HI = 8'(NOTE_OFFSET + NUM_KEYS - 1);

    // A waiting note keeps its contents.
    `TCKVS_ASSERT_NEXT(a_note_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_note_number) && $stable(i_velocity), "stalled note changed")

    // Only notes of existing keys come out.
    `TCKVS_ASSERT_NOW(a_note_range, i_clk, i_rst_n, i_out_valid, ({1'b0, i_note_number} >= NOTE_LO) && ({1'b0, i_note_number} <= NOTE_HI), "note outside key range")

    // A note that appears in an empty slot comes from a request via stage one.
    `TCKVS_ASSERT_NOW(a_note_origin, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2), "note without a matching request")

    // Requests are only held off behind a waiting note.
    `TCKVS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_in_ready, i_out_valid, "request stalled with the note slot empty")

endmodule

bind two_contact_key_velocity_scanner tckvs_chk #(
    .NUM_KEYS (NUM_KEYS)
) u_tckvs_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_key.valid),
    .i_in_ready    (i_key.ready),
    .i_out_valid   (o_note.valid),
    .i_out_ready   (o_note.ready),
    .i_note_number (o_note.note_number),
    .i_velocity    (o_note.velocity)
);

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key velocity scanner testbench
// Sends key samples through the scanner and checks each sounded note and its
// velocity against a per-key model of press, sound and rearm kept here.
// ----------------------------------------------------------------------------

module tb_top;
    import tckvs_pkg::*;

    // One key sample as it sits on the request channel.
    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             first_contact;
        logic             second_contact;
        logic [NOW_W-1:0] now_tick;
    } t_key_req;

    // One sounded note as it leaves the scanner.
    typedef struct packed {
        logic [KEY_W-1:0] note_number;
        logic [VEL_W-1:0] velocity;
    } t_note;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tckvs_key_if  key_ch ();
    tckvs_note_if note_ch ();

    two_contact_key_velocity_scanner uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (key_ch),
        .o_note     (note_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Requests waiting for the driver, and notes the scanner still owes us.
    t_key_req key_pending [$];
    t_note    notes_due [$];

    int  items_queued  = 0;
    int  items_taken   = 0;
    int  mismatch_cnt  = 0;
    bit  key_fired     = 1'b0;
    int  send_gap      = 0;
    int  send_calm     = 0;
    int  stall_left    = 0;
    int  recv_calm     = 0;

    // Scanner state as the checker sees it: one phase and two timestamps per
    // key, plus a shadow of the three registers.
    t_phase           key_phase_m [NUM_KEYS_DEF];
    logic [NOW_W-1:0] pressed_at  [NUM_KEYS_DEF];
    logic [NOW_W-1:0] sounded_at  [NUM_KEYS_DEF];
    logic [15:0]      rearm_sh;
    logic [7:0]       min_flight_sh;
    logic [7:0]       max_flight_sh;

    // The stimulus side keeps its own idea of the settings and of the time.
    int               stim_rearm = 200;
    int               stim_min   = 1;
    int               stim_max   = 180;
    logic [NOW_W-1:0] tnow       = '0;
    int               prev_key   = 0;

    // The velocity curve 128.43 - 1.43 d + 0.00405 d^2, done exactly in
    // integers. A zero flight gives no velocity, a one-tick flight full scale,
    // and flights past the end of the curve use its last point.
    function automatic logic [VEL_W-1:0] flight_to_velocity(logic [NOW_W-1:0] flight);
        longint d;
        longint v;
        d = (flight >= TABLE_SIZE) ? TABLE_SIZE - 1 : flight;
        if (d == 0) begin
            return '0;
        end
        if (d == 1) begin
            return 7'd127;
        end
        v = (64'sd12843000 - 64'sd143000 * d + 64'sd405 * d * d) / 64'sd100000;
        if (v < 0) begin
            v = 0;
        end
        if (v > 127) begin
            v = 127;
        end
        return VEL_W'(v);
    endfunction

    // Applies one accepted request to the key state. Returns 1 when the
    // request sounds the key, with the note it must produce.
    function automatic bit predict_note(input t_key_req r, output t_note n);
        int               k;
        bit               first_closed;
        bit               second_closed;
        logic [NOW_W-1:0] since_sound;
        logic [NOW_W-1:0] flight;
        n = '0;
        if (r.key_index >= NUM_KEYS_DEF) begin
            return 1'b0;
        end
        k             = r.key_index;
        first_closed  = (r.first_contact == 1'b0);
        second_closed = (r.second_contact == 1'b0);
        since_sound   = r.now_tick - sounded_at[k];
        if (first_closed) begin
            if (key_phase_m[k] == PH_IDLE) begin
                // A press only arms the key once the guard after its last
                // note has run out.
                if (since_sound > rearm_sh) begin
                    pressed_at[k]  = r.now_tick;
                    key_phase_m[k] = PH_ARMED;
                end
            end else if (second_closed && key_phase_m[k] == PH_ARMED) begin
                flight = r.now_tick - pressed_at[k];
                if (flight > min_flight_sh && flight < max_flight_sh) begin
                    sounded_at[k]  = r.now_tick;
                    key_phase_m[k] = PH_SOUNDED;
                    n.note_number  = KEY_W'(k) + NOTE_OFFSET;
                    n.velocity     = flight_to_velocity(flight);
                    return 1'b1;
                end
            end
        end else if (key_phase_m[k] != PH_IDLE) begin
            // An open first contact drops the key back to idle, but not
            // while the guard after a note is still running.
            if (since_sound > rearm_sh) begin
                key_phase_m[k] = PH_IDLE;
            end
        end
        return 1'b0;
    endfunction

    // Gap length for either side: mostly none or short, now and then long,
    // and every so often a calm stretch with no gaps at all.
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Request driver: changes the channel on the falling edge only. A new
    // request goes out once the previous one was taken at the last rising edge.
    always @(negedge i_clk) begin : key_driver
        t_key_req nxt;
        if (!i_rst_n) begin
            key_ch.valid <= 1'b0;
        end else if (!key_ch.valid || key_fired) begin
            if (send_gap != 0) begin
                send_gap--;
                key_ch.valid <= 1'b0;
            end else if (key_pending.size() != 0) begin
                nxt = key_pending.pop_front();
                key_ch.valid          <= 1'b1;
                key_ch.key_index      <= nxt.key_index;
                key_ch.first_contact  <= nxt.first_contact;
                key_ch.second_contact <= nxt.second_contact;
                key_ch.now_tick       <= nxt.now_tick;
                send_gap = idle_len(send_calm);
            end else begin
                key_ch.valid <= 1'b0;
            end
        end
    end

    // Note receiver: stalls of random length between stretches of ready.
    always @(negedge i_clk) begin : note_receiver
        if (!i_rst_n) begin
            note_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            note_ch.ready <= 1'b0;
        end else begin
            note_ch.ready <= 1'b1;
            stall_left = idle_len(recv_calm);
        end
    end

    // Monitor: on each rising edge, check a delivered note against the oldest
    // one owed, then follow register writes and accepted requests. The note
    // is checked first so that a request can never vouch for a note that
    // leaves in the same cycle it arrives.
    always @(posedge i_clk) begin : note_monitor
        t_key_req req;
        t_note    due;
        t_note    pred;
        key_fired = 1'b0;
        if (i_rst_n) begin
            if (note_ch.valid && note_ch.ready) begin
                if (notes_due.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected note, expected none, got note %0d velocity %0d",
                             $time, note_ch.note_number, note_ch.velocity);
                end else begin
                    due = notes_due.pop_front();
                    if (note_ch.note_number !== due.note_number) begin
                        mismatch_cnt++;
                        $display("%0t: note_number mismatch, expected %0d, got %0d",
                                 $time, due.note_number, note_ch.note_number);
                    end
                    if (note_ch.velocity !== due.velocity) begin
                        mismatch_cnt++;
                        $display("%0t: velocity mismatch, expected %0d, got %0d",
                                 $time, due.velocity, note_ch.velocity);
                    end
                end
            end
            if (cfg_we) begin
                case (t_cfg_reg'(cfg_idx))
                    CFG_REARM: begin
                        rearm_sh = cfg_data;
                    end
                    CFG_MIN_FLIGHT: begin
                        min_flight_sh = cfg_data[7:0];
                    end
                    CFG_MAX_FLIGHT: begin
                        max_flight_sh = cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (key_ch.valid && key_ch.ready) begin
                key_fired          = 1'b1;
                req.key_index      = key_ch.key_index;
                req.first_contact  = key_ch.first_contact;
                req.second_contact = key_ch.second_contact;
                req.now_tick       = key_ch.now_tick;
                items_taken++;
                if (predict_note(req, pred)) begin
                    notes_due.push_back(pred);
                end
            end
        end
    end

    task automatic queue_req(input int k, input bit first_lvl, input bit second_lvl,
                             input logic [NOW_W-1:0] at_tick);
        t_key_req r;
        r.key_index      = KEY_W'(k);
        r.first_contact  = first_lvl;
        r.second_contact = second_lvl;
        r.now_tick       = at_tick;
        key_pending.push_back(r);
        items_queued++;
    endtask

    // Waits until every queued request was taken and every note has come,
    // then waits on so that a request that makes no note also leaves the
    // two-stage pipeline.
    task automatic drain_notes();
        while (items_taken != items_queued || notes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DATA_W'(val);
    endtask

    // Registers change only with the scanner idle.
    task automatic apply_config(input int rearm, input int min_f, input int max_f);
        drain_notes();
        write_reg(CFG_REARM, rearm);
        write_reg(CFG_MIN_FLIGHT, min_f);
        write_reg(CFG_MAX_FLIGHT, max_f);
        @(negedge i_clk);
        cfg_we     <= 1'b0;
        stim_rearm = rearm;
        stim_min   = min_f;
        stim_max   = max_f;
    endtask

    // Random traffic. Most of it is whole keystrokes: press, second contact
    // after a flight time near the window, release around the rearm guard.
    // The rest is stray samples on any key index and strokes cut short.
    task automatic gen_keystrokes(input int n_items);
        int               made;
        int               k;
        int               f;
        int               g;
        int               sel;
        logic [NOW_W-1:0] t0;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                k = $urandom_range(0, 127);
                if ($urandom_range(0, 3) == 0) begin
                    t0 = $urandom;
                end else begin
                    t0 = tnow + $urandom_range(0, 300);
                end
                queue_req(k, $urandom_range(0, 1), $urandom_range(0, 1), t0);
                if (k < NUM_KEYS_DEF) begin
                    made++;
                end
            end else begin
                // Reusing the last key presses it again right after its note,
                // which is where the rearm guard matters.
                k = ($urandom_range(0, 3) == 0) ? prev_key
                                                : $urandom_range(0, NUM_KEYS_DEF - 1);
                if ($urandom_range(0, 4) == 0) begin
                    t0 = tnow + $urandom_range(0, stim_rearm);
                end else begin
                    t0 = tnow + stim_rearm + 1 + $urandom_range(0, 40);
                end
                queue_req(k, 1'b0, ($urandom_range(0, 5) != 0), t0);
                made++;

                sel = $urandom_range(0, 9);
                if (sel < 7 && stim_min + 1 <= stim_max - 1) begin
                    f = $urandom_range(stim_min + 1, stim_max - 1);
                end else begin
                    case ($urandom_range(0, 5))
                        0: f = stim_min;
                        1: f = stim_min + 1;
                        2: f = stim_max - 1;
                        3: f = stim_max;
                        4: f = $urandom_range(0, 3);
                        default: f = $urandom_range(0, 300);
                    endcase
                end
                if (f > 0 && $urandom_range(0, 3) == 0) begin
                    // First contact held while the hammer is still in flight.
                    queue_req(k, 1'b0, 1'b1, t0 + $urandom_range(0, f - 1));
                    made++;
                end
                if ($urandom_range(0, 6) != 0) begin
                    queue_req(k, 1'b0, 1'b0, t0 + f);
                    made++;
                    if ($urandom_range(0, 4) == 0) begin
                        // Contact bounce after the note.
                        queue_req(k, 1'b0, $urandom_range(0, 1), t0 + f + $urandom_range(1, 5));
                        made++;
                    end
                end

                sel = $urandom_range(0, 9);
                if (sel < 6) begin
                    g = stim_rearm + 1 + $urandom_range(0, 20);
                end else if (sel < 8) begin
                    g = $urandom_range(0, stim_rearm);
                end else if (sel == 8) begin
                    g = stim_rearm;
                end else begin
                    g = stim_rearm + 1;
                end
                queue_req(k, 1'b1, $urandom_range(0, 1), t0 + f + g);
                made++;
                tnow = t0 + f + g;
                if ($urandom_range(0, 4) == 0) begin
                    // A later release that clears a key the guard still held.
                    tnow = t0 + f + stim_rearm + 1 + $urandom_range(0, 10);
                    queue_req(k, 1'b1, 1'b1, tnow);
                    made++;
                end
                prev_key = k;
            end
        end
    endtask

    initial begin : stimulus
        int r_rearm;
        int r_min;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_REARM;
        cfg_data              = '0;
        key_ch.valid          = 1'b0;
        key_ch.key_index      = '0;
        key_ch.first_contact  = 1'b1;
        key_ch.second_contact = 1'b1;
        key_ch.now_tick       = '0;
        note_ch.ready         = 1'b0;
        rearm_sh              = REARM_RST;
        min_flight_sh         = MIN_FLIGHT_RST;
        max_flight_sh         = MAX_FLIGHT_RST;
        for (int i = 0; i < NUM_KEYS_DEF; i++) begin
            key_phase_m[i] = PH_IDLE;
            pressed_at[i]  = '0;
            sounded_at[i]  = '0;
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset settings (guard 200, window 2..179).
        // Key 0: a fast stroke, bounce, release inside and past the guard,
        // then a one-tick flight that is too short and the longest one allowed.
        queue_req(0, 1'b0, 1'b1, 32'd1000);
        queue_req(0, 1'b0, 1'b0, 32'd1002);
        queue_req(0, 1'b0, 1'b0, 32'd1003);
        queue_req(0, 1'b1, 1'b1, 32'd1202);
        queue_req(0, 1'b0, 1'b1, 32'd1202);
        queue_req(0, 1'b1, 1'b0, 32'd1203);
        queue_req(0, 1'b0, 1'b1, 32'd1300);
        queue_req(0, 1'b0, 1'b0, 32'd1301);
        queue_req(0, 1'b0, 1'b0, 32'd1479);
        // Top key with a flight that crosses the tick wrap.
        queue_req(87, 1'b0, 1'b1, 32'hFFFF_FFF0);
        queue_req(87, 1'b0, 1'b0, 32'h0000_0010);
        // Key indexes past the keyboard are ignored.
        queue_req(88, 1'b0, 1'b0, 32'd5000);
        queue_req(127, 1'b0, 1'b1, $urandom);
        // Second contact alone does nothing; both at once only arm the key;
        // a flight of exactly the maximum does not sound; open first contact
        // lets the armed key go idle.
        queue_req(5, 1'b1, 1'b0, 32'd5000);
        queue_req(5, 1'b0, 1'b0, 32'd5000);
        queue_req(5, 1'b0, 1'b0, 32'd5180);
        queue_req(5, 1'b1, 1'b1, 32'd5201);
        // Key 6 around the guard: held inside it, idle after it, and a quick
        // restrike once it has run out.
        queue_req(6, 1'b0, 1'b1, 32'h7FFF_FFFF);
        queue_req(6, 1'b0, 1'b0, 32'h8000_0040);
        queue_req(6, 1'b1, 1'b1, 32'h8000_00A4);
        queue_req(6, 1'b0, 1'b1, 32'h8000_00D6);
        queue_req(6, 1'b1, 1'b1, 32'h8000_0109);
        queue_req(6, 1'b0, 1'b1, 32'h8000_010D);
        queue_req(6, 1'b0, 1'b0, 32'h8000_010F);

        // No guard and the widest window, so a one-tick flight sounds at full
        // scale. Halfway through, the sender holds off until every note is in.
        apply_config(0, 0, 180);
        tnow = 32'hFFFF_F000;
        gen_keystrokes(55);
        drain_notes();
        gen_keystrokes(55);

        // Longest guard with a narrow window.
        apply_config(65535, 50, 120);
        tnow = 32'hFFF0_0000;
        gen_keystrokes(90);

        // Windows that no flight can fall into.
        apply_config(17, 179, 180);
        tnow = $urandom;
        gen_keystrokes(40);
        apply_config(0, 0, 1);
        gen_keystrokes(30);

        // Two random settings.
        repeat (2) begin
            r_rearm = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 3000);
            r_min   = $urandom_range(0, 120);
            apply_config(r_rearm, r_min, $urandom_range(r_min + 2, 180));
            tnow = $urandom;
            gen_keystrokes(100);
        end

        // Back to the reset values, written this time.
        apply_config(200, 1, 180);
        gen_keystrokes(80);

        drain_notes();
        repeat (10) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #500000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
